// ===== sv/arc_pkg.sv =====
// shared types, constants and codes of the arp responder cache
package arc_pkg;

  // cache geometry
  localparam int CACHE_ENTRIES = 8;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  // field widths
  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'd1;

  // packet codes
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;

  // result status codes
  localparam logic [2:0] ST_UPDATED   = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_HW    = 3'd3;
  localparam logic [2:0] ST_BAD_PROTO = 3'd4;
  localparam logic [2:0] ST_NOT_US    = 3'd5;

  // one parsed arp packet
  typedef struct packed {
    logic [15:0]      hardware_type;
    logic [15:0]      protocol_type;
    logic [15:0]      arp_op;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [IP_W-1:0]  target_ip;
  } arc_in_t;

  // one result
  typedef struct packed {
    logic [2:0]       status;
    logic             send_reply;
    logic [MAC_W-1:0] reply_target_mac;
    logic [IP_W-1:0]  reply_target_ip;
    logic [MAC_W-1:0] reply_sender_mac;
    logic [IP_W-1:0]  reply_sender_ip;
  } arc_out_t;

  // one cache entry as stored in memory
  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } arc_entry_t;

  localparam int ENTRY_W = $bits(arc_entry_t);

endpackage

// ===== sv/arc_ram.sv =====
// generic single write port ram with registered read
module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/arc_ctrl.sv =====
// request sequencer: cache walk, valid bits, update decision and result build
module arc_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  arc_pkg::arc_in_t          in_data,
  input  logic [arc_pkg::IP_W-1:0]  own_ip,
  input  logic [arc_pkg::MAC_W-1:0] own_mac,
  output logic                      ram_we,
  output logic [arc_pkg::IDX_W-1:0] ram_waddr,
  output arc_pkg::arc_entry_t       ram_wdata,
  output logic                      ram_re,
  output logic [arc_pkg::IDX_W-1:0] ram_raddr,
  input  arc_pkg::arc_entry_t       ram_rdata,
  output logic                      res_valid,
  input  logic                      res_ready,
  output arc_pkg::arc_out_t         res_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam logic [arc_pkg::IDX_W-1:0] LAST_IDX =
    arc_pkg::IDX_W'(arc_pkg::CACHE_ENTRIES - 1);

  logic [1:0]                        state_r, state_nxt;
  arc_pkg::arc_in_t                  item_r, item_nxt;
  logic [arc_pkg::IDX_W-1:0]         cnt_r, cnt_nxt;
  logic                              cmp_v_r, cmp_v_nxt;
  logic [arc_pkg::IDX_W-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                              hit_r, hit_nxt;
  logic [arc_pkg::IDX_W-1:0]         hit_idx_r, hit_idx_nxt;
  logic                              free_r, free_nxt;
  logic [arc_pkg::IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic [arc_pkg::CACHE_ENTRIES-1:0] valid_r, valid_nxt;

  logic hw_ok;
  logic proto_ok;
  logic good;
  logic for_us;
  logic reply;
  logic [2:0] status;

  // packet classification of the held request
  assign hw_ok    = (item_r.hardware_type == arc_pkg::HW_ETHERNET);
  assign proto_ok = (item_r.protocol_type == arc_pkg::PROTO_IPV4);
  assign good     = hw_ok && proto_ok;
  assign for_us   = (item_r.target_ip == own_ip);
  assign reply    = good && for_us && (item_r.arp_op == arc_pkg::OP_REQUEST);

  // status priority
  always_comb begin
    if (!hw_ok) begin
      status = arc_pkg::ST_BAD_HW;
    end else if (!proto_ok) begin
      status = arc_pkg::ST_BAD_PROTO;
    end else if (hit_r) begin
      status = arc_pkg::ST_UPDATED;
    end else if (!for_us) begin
      status = arc_pkg::ST_NOT_US;
    end else if (free_r) begin
      status = arc_pkg::ST_INSERTED;
    end else begin
      status = arc_pkg::ST_FULL;
    end
  end

  // result fields, reply fields zero unless a reply goes out
  always_comb begin
    res_data.status           = status;
    res_data.send_reply       = reply;
    res_data.reply_target_mac = reply ? item_r.sender_mac : '0;
    res_data.reply_target_ip  = reply ? item_r.sender_ip  : '0;
    res_data.reply_sender_mac = reply ? own_mac           : '0;
    res_data.reply_sender_ip  = reply ? own_ip            : '0;
  end

  assign in_stall = (state_r != S_IDLE);

  // sequencer and walk bookkeeping
  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    cnt_nxt      = cnt_r;
    cmp_v_nxt    = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    valid_nxt    = valid_r;
    ram_re       = 1'b0;
    ram_raddr    = cnt_r;
    ram_we       = 1'b0;
    ram_waddr    = hit_idx_r;
    ram_wdata.ip  = item_r.sender_ip;
    ram_wdata.mac = item_r.sender_mac;
    res_valid    = 1'b0;

    // compare stage: entry read last cycle
    if (cmp_v_r) begin
      if (!hit_r && valid_r[cmp_idx_r] && (ram_rdata.ip == item_r.sender_ip)) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = cmp_idx_r;
      end
      if (!free_r && !valid_r[cmp_idx_r]) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          cnt_nxt  = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          if ((in_data.hardware_type == arc_pkg::HW_ETHERNET) &&
              (in_data.protocol_type == arc_pkg::PROTO_IPV4)) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_WALK: begin
        ram_re      = 1'b1;
        cmp_v_nxt   = 1'b1;
        cmp_idx_nxt = cnt_r;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
          // write back: refresh on hit, else insert when addressed to us and an entry is free
          if (good) begin
            if (hit_r) begin
              ram_we    = 1'b1;
              ram_waddr = hit_idx_r;
            end else if (for_us && free_r) begin
              ram_we               = 1'b1;
              ram_waddr            = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmp_v_r <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      cmp_v_r <= cmp_v_nxt;
      hit_r   <= hit_nxt;
      free_r  <= free_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload and index registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cnt_r      <= cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

endmodule

// ===== sv/arp_request_responder_cache_unit.sv =====
// top level of the arp responder with address cache
//
// Usage:
//   in_*  : one parsed arp packet per request, taken when in_valid is high
//           and in_stall is low.
//   out_* : one result per request (status and reply fields), taken when
//           out_valid is high and out_stall is low.
//   cfg_* : own_ip and own_mac, written while the block is idle.
// Sequencing: a good packet walks the entry memory one read per cycle,
//   then passes through the drain step to the final step, where its result
//   loads the output register. Packets with a bad hardware or protocol type
//   skip the walk and the drain and go straight to the final step.
//   One request is in work at a time; the next is taken only once the
//   sequencer is back in idle, after the current result has moved into
//   the output register.
// Reset: own_ip and own_mac go to zero and every cache entry is marked free;
//   entry contents are only read behind their valid bits.
// Stall: a result held by out_stall keeps the sequencer at its final step
//   until the output register frees, so no request is lost.
module arp_request_responder_cache_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  arc_pkg::arc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output arc_pkg::arc_out_t              out_data,
  input  logic                           cfg_wr_en,
  input  logic [arc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [arc_pkg::IP_W-1:0]  own_ip_r;
  logic [arc_pkg::MAC_W-1:0] own_mac_r;

  logic                      ram_we;
  logic [arc_pkg::IDX_W-1:0] ram_waddr;
  arc_pkg::arc_entry_t       ram_wdata;
  logic                      ram_re;
  logic [arc_pkg::IDX_W-1:0] ram_raddr;
  arc_pkg::arc_entry_t       ram_rdata;

  logic                      res_valid;
  logic                      res_ready;
  arc_pkg::arc_out_t         res_data;

  logic                      out_valid_r;
  arc_pkg::arc_out_t         out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        arc_pkg::CFG_OWN_IP:  own_ip_r  <= cfg_data[arc_pkg::IP_W-1:0];
        arc_pkg::CFG_OWN_MAC: own_mac_r <= cfg_data[arc_pkg::MAC_W-1:0];
        default: ;
      endcase
    end
  end

  // entry memory: ip and mac side by side
  arc_ram #(
    .WIDTH (arc_pkg::ENTRY_W),
    .DEPTH (arc_pkg::CACHE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request sequencer
  arc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .own_ip    (own_ip_r),
    .own_mac   (own_mac_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // output register frees when empty or being taken
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an accepted request keeps the input side busy the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // a result only loads into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a pending output");

  // a reply only goes out for a good packet addressed to us
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.send_reply) |->
      (out_data.status != arc_pkg::ST_BAD_HW) &&
      (out_data.status != arc_pkg::ST_BAD_PROTO) &&
      (out_data.status != arc_pkg::ST_NOT_US))
    else $error("reply on a dropped packet");

  // reply fields are zero without a reply
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.send_reply) |->
      (out_data.reply_target_mac == '0) && (out_data.reply_target_ip == '0) &&
      (out_data.reply_sender_mac == '0) && (out_data.reply_sender_ip == '0))
    else $error("reply fields set without a reply");

endmodule

// ===== test/arp_request_responder_cache_unit_tb.sv =====
// testbench for the arp responder with address cache: predicted results checked in order
`timescale 1ns / 100ps

module arp_request_responder_cache_unit_tb;

  // scoreboard: mirrors the cache and the own address, queues the awaited answers
  class arp_cache_scoreboard;
    logic [arc_pkg::IP_W-1:0]  my_ip;
    logic [arc_pkg::MAC_W-1:0] my_mac;
    bit                        entry_valid [arc_pkg::CACHE_ENTRIES];
    logic [arc_pkg::IP_W-1:0]  entry_ip    [arc_pkg::CACHE_ENTRIES];
    logic [arc_pkg::MAC_W-1:0] entry_mac   [arc_pkg::CACHE_ENTRIES];
    arc_pkg::arc_out_t         awaited_answers[$];
    int                        mismatches;

    function new();
      int k;
      my_ip      = '0;
      my_mac     = '0;
      mismatches = 0;
      for (k = 0; k < arc_pkg::CACHE_ENTRIES; k++) begin
        entry_valid[k] = 1'b0;
        entry_ip[k]    = '0;
        entry_mac[k]   = '0;
      end
    endfunction

    function void write_reg(logic [arc_pkg::CFG_IDX_W-1:0] idx,
                            logic [arc_pkg::CFG_DATA_W-1:0] value);
      if (idx == arc_pkg::CFG_OWN_IP) begin
        my_ip = value[arc_pkg::IP_W-1:0];
      end else begin
        my_mac = value[arc_pkg::MAC_W-1:0];
      end
    endfunction

    function int outstanding();
      return awaited_answers.size();
    endfunction

    // work out the answer of one accepted request and update the cache copy
    function void note_request(arc_pkg::arc_in_t req);
      arc_pkg::arc_out_t ans;
      bit                hit;
      bit                for_us;
      int                k;
      ans = '0;
      if (req.hardware_type != arc_pkg::HW_ETHERNET) begin
        ans.status = arc_pkg::ST_BAD_HW;
      end else if (req.protocol_type != arc_pkg::PROTO_IPV4) begin
        ans.status = arc_pkg::ST_BAD_PROTO;
      end else begin
        // merge into the lowest matching valid entry
        hit = 1'b0;
        for (k = 0; k < arc_pkg::CACHE_ENTRIES; k++) begin
          if (!hit && entry_valid[k] && entry_ip[k] == req.sender_ip) begin
            entry_mac[k] = req.sender_mac;
            hit = 1'b1;
          end
        end
        for_us = (req.target_ip == my_ip);
        if (hit) begin
          ans.status = arc_pkg::ST_UPDATED;
        end else if (!for_us) begin
          ans.status = arc_pkg::ST_NOT_US;
        end else begin
          // insert into the lowest free entry
          ans.status = arc_pkg::ST_FULL;
          for (k = 0; k < arc_pkg::CACHE_ENTRIES; k++) begin
            if (ans.status == arc_pkg::ST_FULL && !entry_valid[k]) begin
              entry_valid[k] = 1'b1;
              entry_ip[k]    = req.sender_ip;
              entry_mac[k]   = req.sender_mac;
              ans.status     = arc_pkg::ST_INSERTED;
            end
          end
        end
        // reply only to requests aimed at us
        if (for_us && req.arp_op == arc_pkg::OP_REQUEST) begin
          ans.send_reply       = 1'b1;
          ans.reply_target_mac = req.sender_mac;
          ans.reply_target_ip  = req.sender_ip;
          ans.reply_sender_mac = my_mac;
          ans.reply_sender_ip  = my_ip;
        end
      end
      awaited_answers.push_back(ans);
    endfunction

    // compare one result with the oldest awaited answer
    function void check_answer(arc_pkg::arc_out_t got);
      arc_pkg::arc_out_t want;
      if (awaited_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status=%0d reply=%0b", $realtime, got.status,
                   got.send_reply);
        return;
      end
      want = awaited_answers.pop_front();
      if (got.status !== want.status || got.send_reply !== want.send_reply ||
          got.reply_target_mac !== want.reply_target_mac ||
          got.reply_target_ip !== want.reply_target_ip ||
          got.reply_sender_mac !== want.reply_sender_mac ||
          got.reply_sender_ip !== want.reply_sender_ip) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch expected st=%0d rep=%0b tmac=%h tip=%h smac=%h sip=%h",
                   $realtime, want.status, want.send_reply, want.reply_target_mac,
                   want.reply_target_ip, want.reply_sender_mac, want.reply_sender_ip);
          $display("%0t:          actual   st=%0d rep=%0b tmac=%h tip=%h smac=%h sip=%h",
                   $realtime, got.status, got.send_reply, got.reply_target_mac,
                   got.reply_target_ip, got.reply_sender_mac, got.reply_sender_ip);
        end
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  arc_pkg::arc_in_t               in_data;
  logic                           out_valid;
  logic                           out_stall;
  arc_pkg::arc_out_t              out_data;
  logic                           cfg_wr_en;
  logic [arc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [arc_pkg::CFG_DATA_W-1:0] cfg_data;

  arp_cache_scoreboard sb;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  bit                  hold_req;

  arp_request_responder_cache_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // watch both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_answer(out_data);
    end
  end

  // receiver: random stall, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic arc_pkg::arc_in_t pack_request(logic [15:0] hw, logic [15:0] proto,
                                                    logic [15:0] op, logic [47:0] smac,
                                                    logic [31:0] sip, logic [31:0] tip);
    arc_pkg::arc_in_t r;
    r.hardware_type = hw;
    r.protocol_type = proto;
    r.arp_op        = op;
    r.sender_mac    = smac;
    r.sender_ip     = sip;
    r.target_ip     = tip;
    return r;
  endfunction

  // random packet: mostly well formed, senders often from the cache
  function automatic arc_pkg::arc_in_t make_request();
    arc_pkg::arc_in_t r;
    int               pick;
    int               slot;
    r.hardware_type = arc_pkg::HW_ETHERNET;
    r.protocol_type = arc_pkg::PROTO_IPV4;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r.hardware_type = 16'($urandom);
    end else if (pick < 12) begin
      r.hardware_type = arc_pkg::HW_ETHERNET ^ (16'd1 << $urandom_range(0, 15));
    end else if (pick < 18) begin
      r.protocol_type = 16'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) r.arp_op = arc_pkg::OP_REQUEST;
    else if (pick < 80) r.arp_op = 16'd2;
    else r.arp_op = 16'($urandom);
    r.sender_mac = rand48();
    slot = $urandom_range(0, arc_pkg::CACHE_ENTRIES - 1);
    if ($urandom_range(0, 99) < 55 && sb.entry_valid[slot]) r.sender_ip = sb.entry_ip[slot];
    else r.sender_ip = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 60) r.target_ip = sb.my_ip;
    else if (pick < 70) r.target_ip = sb.my_ip ^ (32'd1 << $urandom_range(0, 31));
    else r.target_ip = $urandom;
    return r;
  endfunction

  // one register write, starting at a falling edge
  task automatic write_reg(logic [arc_pkg::CFG_IDX_W-1:0] idx,
                           logic [arc_pkg::CFG_DATA_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // offer one request with random idle cycles ahead of it
  task automatic send_request(arc_pkg::arc_in_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_data  = pack_request(16'($urandom), 16'($urandom), 16'($urandom), rand48(),
                              $urandom, $urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // hold the sender until every answer is in, then let the block settle
  task automatic drain();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (16) @(negedge clk);
  endtask

  initial begin
    int seg;
    int n;
    int k;
    sb            = new();
    send_idle_pct = 10;
    recv_idle_pct = 82;
    hold_req      = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = arc_pkg::CFG_OWN_IP;
    cfg_data      = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part
    write_reg(arc_pkg::CFG_OWN_IP, {16'hABCD, 32'hC0A8_0A01});
    write_reg(arc_pkg::CFG_OWN_MAC, 48'h02AB_CDEF_0001);
    // bad hardware, even a request for us
    send_request(pack_request(16'h0000, arc_pkg::PROTO_IPV4, arc_pkg::OP_REQUEST, rand48(),
                              32'h0A00_0001, sb.my_ip));
    send_request(pack_request(16'hFFFF, 16'hFFFF, arc_pkg::OP_REQUEST, rand48(),
                              32'h0A00_0001, sb.my_ip));
    // bad protocol
    send_request(pack_request(arc_pkg::HW_ETHERNET, 16'h0000, arc_pkg::OP_REQUEST, rand48(),
                              32'h0A00_0001, sb.my_ip));
    send_request(pack_request(arc_pkg::HW_ETHERNET, 16'hFFFF, 16'd2, rand48(),
                              32'h0A00_0001, sb.my_ip));
    // not for us, nothing cached
    send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, arc_pkg::OP_REQUEST,
                              rand48(), 32'h0A00_0001, 32'h0000_0000));
    // inserts with every kind of opcode and the address extremes
    send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, arc_pkg::OP_REQUEST,
                              48'h0, 32'h0, sb.my_ip));
    send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, 16'd2,
                              48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, sb.my_ip));
    send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, 16'h0000, rand48(),
                              32'h0A00_0003, sb.my_ip));
    send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, 16'hFFFF, rand48(),
                              32'h0A00_0004, sb.my_ip));
    // merge for us with reply, merge not for us
    send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, arc_pkg::OP_REQUEST,
                              rand48(), 32'h0, sb.my_ip));
    send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, arc_pkg::OP_REQUEST,
                              rand48(), 32'hFFFF_FFFF, 32'h1234_5678));
    // fill the rest of the table
    for (k = 5; k <= 8; k++)
      send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, 16'($urandom),
                                rand48(), 32'h0A00_0000 + k, sb.my_ip));
    // table full, request and reply
    send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, arc_pkg::OP_REQUEST,
                              rand48(), 32'h0A00_00FF, sb.my_ip));
    send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, 16'd2, rand48(),
                              32'h0A00_00FE, sb.my_ip));
    // not for us with a full table
    send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, arc_pkg::OP_REQUEST,
                              rand48(), 32'h0A00_00FD, ~sb.my_ip));
    // merge into the last entry
    send_request(pack_request(arc_pkg::HW_ETHERNET, arc_pkg::PROTO_IPV4, arc_pkg::OP_REQUEST,
                              rand48(), 32'h0A00_0008, sb.my_ip));
    // bad protocol from a cached sender leaves it alone
    send_request(pack_request(arc_pkg::HW_ETHERNET, 16'h0806, arc_pkg::OP_REQUEST, rand48(),
                              32'h0A00_0008, sb.my_ip));

    // random part in six segments, idling pattern changes every two
    for (seg = 0; seg < 6; seg++) begin
      drain();
      send_idle_pct = (seg < 2) ? 10 : (seg < 4) ? 82 : 0;
      recv_idle_pct = (seg < 2) ? 82 : (seg < 4) ? 10 : 0;
      case (seg)
        0: begin
          write_reg(arc_pkg::CFG_OWN_IP, '0);
          write_reg(arc_pkg::CFG_OWN_MAC, '0);
        end
        1: begin
          write_reg(arc_pkg::CFG_OWN_IP, {arc_pkg::CFG_DATA_W{1'b1}});
          write_reg(arc_pkg::CFG_OWN_MAC, {arc_pkg::CFG_DATA_W{1'b1}});
        end
        default: begin
          write_reg(arc_pkg::CFG_OWN_IP, rand48());
          write_reg(arc_pkg::CFG_OWN_MAC, rand48());
        end
      endcase
      for (n = 0; n < 290; n++) begin
        if (seg == 4 && n == 40) hold_req = 1'b1;
        send_request(make_request());
      end
    end

    // wind down
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/arc_pkg.sv
sv/arc_ram.sv
sv/arc_ctrl.sv
sv/arp_request_responder_cache_unit.sv
test/arp_request_responder_cache_unit_tb.sv
